### rtl/multi_sensor_wrap_unwrap_tracker_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multi-sensor unwrap tracker.
// ----------------------------------------------------------------------------
`ifndef MULTI_SENSOR_WRAP_UNWRAP_TRACKER_MACROS_SVH
`define MULTI_SENSOR_WRAP_UNWRAP_TRACKER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MSWU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MSWU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mswu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mswu_pkg
// Shared types and constants of the multi-sensor unwrap tracker.
// ----------------------------------------------------------------------------
package mswu_pkg;

  localparam int IDX_W      = 6;
  localparam int RAW_W      = 16;
  localparam int CNT_W      = 10;
  localparam int VAL_W      = 16;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 32;
  localparam int WRAP_HALF  = 512;
  localparam int WRAP_SPAN  = 1024;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_OFFSET = 1'b1
  } opcode_t;

  // One row of per-sensor state.
  typedef struct packed {
    logic [VAL_W-1:0] offset;
    logic [VAL_W-1:0] unwrapped;
    logic [CNT_W-1:0] prev_count;
  } row_t;

  // An accepted word after the justification shift.
  typedef struct packed {
    opcode_t          op;
    logic [IDX_W-1:0] sensor;
    logic [CNT_W-1:0] p_count;
    logic [CNT_W-1:0] t_count;
    logic [VAL_W-1:0] offset;
  } item_t;

endpackage

### rtl/mswu_state_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mswu_state_mem
// Per-sensor state memory with registered read, write-to-read bypass and
// per-row valid bits so that unwritten rows read as zero.
// ----------------------------------------------------------------------------
module mswu_state_mem #(
  parameter int DEPTH = 48,
  parameter int AW    = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  mswu_pkg::row_t    wr_data,
  output mswu_pkg::row_t    rd_row
);
  import mswu_pkg::*;

  row_t             mem [0:DEPTH-1];
  row_t             rd_data_r;
  logic [AW-1:0]    rd_addr_r;
  logic [DEPTH-1:0] vld_r;
  logic             byp_vld_r;
  logic [AW-1:0]    byp_addr_r;
  row_t             byp_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  // The last write is kept so that a read issued in the same cycle still sees it.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      byp_addr_r <= wr_addr;
      byp_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      byp_vld_r <= 1'b0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
      byp_vld_r      <= 1'b1;
    end
  end

  always_comb begin
    if (!vld_r[rd_addr_r]) begin
      rd_row = '0;
    end else if (byp_vld_r && (byp_addr_r == rd_addr_r)) begin
      rd_row = byp_data_r;
    end else begin
      rd_row = rd_data_r;
    end
  end

endmodule

### rtl/mswu_unwrap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mswu_unwrap
// Unwrap step for one word: works out the new state row and the offset
// corrected pressure.
// ----------------------------------------------------------------------------
module mswu_unwrap (
  input  mswu_pkg::item_t           item,
  input  mswu_pkg::row_t            cur_row,
  input  logic                      seeded,
  output mswu_pkg::row_t            new_row,
  output logic [mswu_pkg::VAL_W-1:0] pressure
);
  import mswu_pkg::*;

  localparam logic signed [CNT_W:0] HALF_POS = (CNT_W+1)'(WRAP_HALF);
  localparam logic signed [CNT_W:0] HALF_NEG = (CNT_W+1)'(-WRAP_HALF);

  logic signed [CNT_W:0] diff;
  logic [VAL_W-1:0]      diff_ext;
  logic [VAL_W-1:0]      step;
  logic [VAL_W-1:0]      acc;

  always_comb begin
    diff     = $signed({1'b0, item.p_count}) - $signed({1'b0, cur_row.prev_count});
    diff_ext = {{(VAL_W-CNT_W-1){diff[CNT_W]}}, diff};
    // A step of half the span or more is a wrap and goes the short way round;
    // exactly +512 counts as a wrap across zero, exactly -512 across the top.
    if (diff >= HALF_POS) begin
      step = diff_ext - VAL_W'(WRAP_SPAN);
    end else if (diff <= HALF_NEG) begin
      step = diff_ext + VAL_W'(WRAP_SPAN);
    end else begin
      step = diff_ext;
    end
    if (seeded) begin
      acc = cur_row.unwrapped + step;
    end else begin
      acc = {{(VAL_W-CNT_W){1'b0}}, item.p_count};
    end
  end

  always_comb begin
    new_row = cur_row;
    case (item.op)
      OP_SAMPLE: begin
        new_row.unwrapped  = acc;
        new_row.prev_count = item.p_count;
      end
      OP_OFFSET: begin
        new_row.offset = item.offset;
      end
      default: begin
        new_row = cur_row;
      end
    endcase
  end

  assign pressure = acc - cur_row.offset;

endmodule

### rtl/multi_sensor_wrap_unwrap_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_sensor_wrap_unwrap_tracker
// Per-sensor unwrap of 10-bit pressure counts with offset correction.
// A result word passes the input stage, then the result register; the input
// stage holds a sample while the result register is full and not taken.
// Throughput: one word per cycle unless the output stalls; the state memory does
// one read and one write per cycle, with a bypass for back-to-back same-sensor words.
// Reset clears control, seeded and row-valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
`include "multi_sensor_wrap_unwrap_tracker_macros.svh"

module multi_sensor_wrap_unwrap_tracker #(
  parameter int NUM_SENSORS = 48
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // sensor_index[5:0], raw_pressure[21:6], raw_temperature[37:22],
  // offset_value[53:38], zero fill above
  input  logic [mswu_pkg::IN_DATA_W-1:0]    in_tdata,
  // opcode
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_sensor[5:0], pressure_out[21:6], temperature_out[31:22]
  output logic [mswu_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import mswu_pkg::*;

  localparam int AW = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

  logic [IDX_W-1:0] in_sensor;
  logic [RAW_W-1:0] in_praw;
  logic [RAW_W-1:0] in_traw;
  logic [VAL_W-1:0] in_offs;
  opcode_t          in_op;
  logic             in_acc;
  logic             in_useful;
  item_t            in_item;

  logic             s1_valid_r;
  item_t            s1_item_r;
  logic             s1_adv;
  logic [AW-1:0]    s1_addr;

  row_t             cur_row;
  row_t             new_row;
  logic [VAL_W-1:0] pressure;
  logic [NUM_SENSORS-1:0] seeded_r;

  logic             out_valid_r;
  logic [IDX_W-1:0] out_sensor_r;
  logic [VAL_W-1:0] out_pressure_r;
  logic [CNT_W-1:0] out_temp_r;

  assign in_sensor = in_tdata[5:0];
  assign in_praw   = in_tdata[21:6];
  assign in_traw   = in_tdata[37:22];
  assign in_offs   = in_tdata[53:38];
  assign in_op     = opcode_t'(in_tuser);

  assign in_acc    = in_tvalid && in_tready;
  // Words for a sensor that does not exist, and samples with a zero pressure
  // word, are taken and dropped here.
  assign in_useful = (32'(in_sensor) < 32'(NUM_SENSORS)) &&
                     ((in_op == OP_OFFSET) || (in_praw != '0));

  always_comb begin
    in_item.op      = in_op;
    in_item.sensor  = in_sensor;
    in_item.p_count = in_praw[RAW_W-1 -: CNT_W];
    in_item.t_count = in_traw[RAW_W-1 -: CNT_W];
    in_item.offset  = in_offs;
  end

  // Offset writes leave no result and so never wait for the output register.
  assign s1_adv    = s1_valid_r &&
                     ((s1_item_r.op == OP_OFFSET) || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign s1_addr   = AW'(s1_item_r.sensor);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= in_useful;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_item;
    end
  end

  mswu_state_mem #(
    .DEPTH (NUM_SENSORS),
    .AW    (AW)
  ) u_state_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (AW'(in_sensor)),
    .wr_en   (s1_adv),
    .wr_addr (s1_addr),
    .wr_data (new_row),
    .rd_row  (cur_row)
  );

  mswu_unwrap u_unwrap (
    .item     (s1_item_r),
    .cur_row  (cur_row),
    .seeded   (seeded_r[s1_addr]),
    .new_row  (new_row),
    .pressure (pressure)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seeded_r <= '0;
    end else if (s1_adv && (s1_item_r.op == OP_SAMPLE)) begin
      seeded_r[s1_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && (s1_item_r.op == OP_SAMPLE)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && (s1_item_r.op == OP_SAMPLE)) begin
      out_sensor_r   <= s1_item_r.sensor;
      out_pressure_r <= pressure;
      out_temp_r     <= s1_item_r.t_count;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_temp_r, out_pressure_r, out_sensor_r};

  `MSWU_ASSERT_NXT(a_sample_gives_result, clk, rst_n, s1_adv && (s1_item_r.op == OP_SAMPLE), out_valid_r, "sample left the input stage without a result word")
  `MSWU_ASSERT_IMP(a_result_from_sample, clk, rst_n, $rose(out_valid_r), $past(s1_adv && (s1_item_r.op == OP_SAMPLE)), "result word appeared without a sample")
  `MSWU_ASSERT_NXT(a_offset_no_result, clk, rst_n, s1_adv && (s1_item_r.op == OP_OFFSET) && out_tready, !out_valid_r, "offset write produced a result word")

endmodule

### verif/tb_multi_sensor_wrap_unwrap_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_sensor_wrap_unwrap_tracker
// Drives sample and offset words into the unwrap tracker and checks every
// result word against a per-sensor unwrap predictor kept in the bench. A short
// directed part hits the wrap boundaries and the ignored cases. Ramps then push
// the unwrapped value through 16-bit overflow, a random mix follows, and a
// final back-to-back burst runs without any idling.
// ----------------------------------------------------------------------------
module tb_multi_sensor_wrap_unwrap_tracker;
  import mswu_pkg::*;

  localparam int SENSORS = 48;

  typedef struct {
    bit [IDX_W-1:0] sensor;
    bit [VAL_W-1:0] pressure;
    bit [CNT_W-1:0] temperature;
  } reading_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  // Predictor state, one row per sensor.
  bit             seeded      [SENSORS];
  bit [CNT_W-1:0] last_count  [SENSORS];
  bit [VAL_W-1:0] unwrapped   [SENSORS];
  bit [VAL_W-1:0] offset_tab  [SENSORS];

  reading_t pending_readings[$];

  bit src_idle_en;
  bit sink_idle_en;
  int words_sent;
  int results_seen;
  int offset_writes;
  int ignored_words;
  int fail_count;

  multi_sensor_wrap_unwrap_tracker #(
    .NUM_SENSORS(SENSORS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #400_000;
    $display("Regression FAIL");
    $finish;
  end

  // Works out what one accepted word does to the sensor rows and queues the
  // reading it should produce, if any.
  function automatic void track_word(opcode_t op, bit [IDX_W-1:0] idx,
                                     bit [RAW_W-1:0] praw, bit [RAW_W-1:0] traw,
                                     bit [VAL_W-1:0] offv);
    bit [CNT_W-1:0] pc;
    bit [VAL_W-1:0] acc;
    int             step;
    reading_t       rd;
    if (idx >= SENSORS) begin
      ignored_words++;
      return;
    end
    if (op == OP_OFFSET) begin
      offset_tab[idx] = offv;
      offset_writes++;
      return;
    end
    if (praw == '0) begin
      ignored_words++;
      return;
    end
    pc = praw[RAW_W-1:RAW_W-CNT_W];
    if (!seeded[idx]) begin
      last_count[idx] = pc;
      unwrapped[idx]  = VAL_W'(pc);
      seeded[idx]     = 1'b1;
    end
    acc = unwrapped[idx];
    // A step of half the span or more is read as a wrap and taken the short
    // way round; exactly half the span therefore reverses direction.
    if (pc >= last_count[idx]) begin
      step = int'(pc) - int'(last_count[idx]);
      if (step < WRAP_HALF) acc = acc + VAL_W'(step);
      else acc = acc - VAL_W'(WRAP_SPAN - step);
    end else begin
      step = int'(last_count[idx]) - int'(pc);
      if (step < WRAP_HALF) acc = acc - VAL_W'(step);
      else acc = acc + VAL_W'(WRAP_SPAN - step);
    end
    last_count[idx] = pc;
    unwrapped[idx]  = acc;
    rd.sensor      = idx;
    rd.pressure    = acc - offset_tab[idx];
    rd.temperature = traw[RAW_W-1:RAW_W-CNT_W];
    pending_readings.push_back(rd);
  endfunction

  // Left-justified pressure word for a count, random filler bits underneath.
  function automatic bit [RAW_W-1:0] raw_from_count(bit [CNT_W-1:0] pc);
    bit [RAW_W-1:0] raw;
    raw = {pc, 6'($urandom)};
    if (raw == '0) raw = 16'h0001;
    return raw;
  endfunction

  task automatic send_word(opcode_t op, bit [IDX_W-1:0] idx, bit [RAW_W-1:0] praw,
                           bit [RAW_W-1:0] traw, bit [VAL_W-1:0] offv);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, offv, traw, praw, idx};
    do @(posedge clk); while (!in_tready);
    words_sent++;
    track_word(op, idx, praw, traw, offv);
  endtask

  // Sample whose pressure count moves by delta from the sensor's last count.
  task automatic send_step(bit [IDX_W-1:0] idx, int delta);
    bit [CNT_W-1:0] pc;
    pc = last_count[idx] + CNT_W'(delta);
    send_word(OP_SAMPLE, idx, raw_from_count(pc), 16'($urandom), 16'($urandom));
  endtask

  // Result sink with random back-pressure.
  initial begin
    forever begin
      @(posedge clk);
      if (sink_idle_en && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    reading_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_readings.size() == 0) begin
        $error("result word with no reading pending: tdata=%h", out_tdata);
        fail_count++;
      end else begin
        want = pending_readings.pop_front();
        results_seen++;
        if (out_tdata[5:0] !== want.sensor) begin
          $error("out_sensor mismatch: expected %0d, got %0d", want.sensor,
                 out_tdata[5:0]);
          fail_count++;
        end
        if (out_tdata[21:6] !== want.pressure) begin
          $error("pressure_out mismatch: expected %0d, got %0d",
                 $signed(want.pressure), $signed(out_tdata[21:6]));
          fail_count++;
        end
        if (out_tdata[31:22] !== want.temperature) begin
          $error("temperature_out mismatch: expected %0d, got %0d",
                 want.temperature, out_tdata[31:22]);
          fail_count++;
        end
      end
    end
  end

  // Seeding, both wrap boundaries, field extremes and the ignored words.
  task automatic test_directed();
    send_word(OP_SAMPLE, 6'd0,  16'h0040, 16'hFFFF, 16'h0000);
    send_word(OP_SAMPLE, 6'd0,  16'h0000, 16'hFFFF, 16'h0000);
    send_word(OP_SAMPLE, 6'd0,  16'h003F, 16'h0000, 16'h0000);
    send_word(OP_SAMPLE, 6'd0,  {10'd511, 6'd0}, 16'h8000, 16'h0000);
    send_word(OP_SAMPLE, 6'd0,  {10'd0, 6'd1}, 16'h0040, 16'h0000);
    send_word(OP_SAMPLE, 6'd0,  {10'd512, 6'd0}, 16'h7FFF, 16'h0000);
    send_word(OP_SAMPLE, 6'd0,  {10'd0, 6'd2}, 16'h0000, 16'h0000);
    send_word(OP_SAMPLE, 6'd0,  16'hFFFF, 16'hFFC0, 16'h0000);
    send_word(OP_SAMPLE, 6'd0,  16'h0001, 16'h003F, 16'h0000);
    send_word(OP_OFFSET, 6'd0,  16'h0000, 16'h0000, 16'h7FFF);
    send_word(OP_SAMPLE, 6'd0,  {10'd5, 6'd0}, 16'h1234, 16'h0000);
    send_word(OP_OFFSET, 6'd0,  16'h0000, 16'h0000, 16'h8000);
    send_word(OP_SAMPLE, 6'd0,  {10'd5, 6'd0}, 16'h4321, 16'h0000);
    send_word(OP_SAMPLE, 6'd47, 16'hFFFF, 16'hFFC0, 16'h0000);
    send_word(OP_OFFSET, 6'd47, 16'h0000, 16'h0000, 16'hFFFF);
    send_word(OP_SAMPLE, 6'd47, 16'hFFFF, 16'hFFFF, 16'h0000);
    send_word(OP_SAMPLE, 6'd48, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(OP_SAMPLE, 6'd63, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(OP_OFFSET, 6'd63, 16'hFFFF, 16'hFFFF, 16'h1234);
    send_word(OP_SAMPLE, 6'd1,  16'h8000, 16'h1234, 16'hABCD);
    send_word(OP_OFFSET, 6'd2,  16'hFFFF, 16'hFFFF, 16'h0100);
    send_word(OP_SAMPLE, 6'd2,  16'hFFC0, 16'h0FC0, 16'h0000);
    send_word(OP_SAMPLE, 6'd2,  16'h0040, 16'hF000, 16'h5555);
  endtask

  // Long one-way walks that carry the unwrapped value through 16-bit overflow
  // in both directions.
  task automatic test_unwrap_ramps();
    send_word(OP_OFFSET, 6'd5, 16'h0, 16'h0, 16'($urandom));
    send_word(OP_SAMPLE, 6'd5, raw_from_count(10'($urandom)), 16'($urandom), 16'h0);
    for (int i = 0; i < 200; i++) send_step(6'd5, $urandom_range(330, 511));
    send_word(OP_SAMPLE, 6'd6, raw_from_count(10'($urandom)), 16'($urandom), 16'h0);
    for (int i = 0; i < 60; i++) send_step(6'd6, -$urandom_range(100, 511));
  endtask

  task automatic test_random_mix(int count);
    int             r;
    bit [IDX_W-1:0] idx;
    for (int i = 0; i < count; i++) begin
      r   = $urandom_range(0, 99);
      idx = ($urandom_range(0, 1) == 0) ? IDX_W'($urandom_range(0, 7)) :
                                          IDX_W'($urandom_range(0, SENSORS - 1));
      if (r < 10) begin
        if ($urandom_range(0, 3) == 0) idx = IDX_W'($urandom_range(SENSORS, 63));
        send_word(OP_OFFSET, idx, 16'($urandom), 16'($urandom), 16'($urandom));
      end else if (r < 14) begin
        send_word(OP_SAMPLE, 6'($urandom_range(SENSORS, 63)), 16'($urandom),
                  16'($urandom), 16'($urandom));
      end else if (r < 18) begin
        send_word(OP_SAMPLE, idx, 16'h0000, 16'($urandom), 16'($urandom));
      end else if (r < 45) begin
        send_word(OP_SAMPLE, idx, raw_from_count(10'($urandom)), 16'($urandom),
                  16'($urandom));
      end else if (r < 60) begin
        send_step(idx, $urandom_range(0, 1024) - 512);
      end else begin
        send_step(idx, $urandom_range(0, 60) - 30);
      end
    end
  endtask

  // Back-to-back words on a handful of sensors, no idling on either side.
  task automatic test_back_to_back(int count);
    bit [IDX_W-1:0] idx;
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    for (int i = 0; i < count; i++) begin
      idx = IDX_W'($urandom_range(0, 3));
      if ($urandom_range(0, 7) == 0)
        send_word(OP_OFFSET, idx, 16'($urandom), 16'($urandom), 16'($urandom));
      else
        send_step(idx, $urandom_range(0, 1024) - 512);
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = 1'b0;
    out_tready   = 1'b0;
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_unwrap_ramps();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    test_random_mix(80);
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    test_random_mix(270);
    test_back_to_back(100);
    in_tvalid <= 1'b0;

    while (pending_readings.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d words: %0d offset writes, %0d ignored, %0d readings checked.",
             words_sent, offset_writes, ignored_words, results_seen);
    $display("Covered seeding, both wrap boundaries, 16-bit overflow both ways.");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
